// ===== rtl/core/vm_fetch_stack_frame_unit_macros.svh =====
// assertion macros for the vm fetch, stack and frame unit
// used by the checker file only; no other dependencies
`ifndef VM_FETCH_STACK_FRAME_UNIT_MACROS_SVH
`define VM_FETCH_STACK_FRAME_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define VFSF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vfsf same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define VFSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vfsf next-cycle check failed");

`endif

// ===== rtl/core/vfsf_pkg.sv =====
// shared types, sizes and index helpers of the vm fetch, stack and frame unit
// no dependencies; imported by the top level, both checkers and the testbench top
package vfsf_pkg;

   // storage sizes
   localparam int MEM_BYTES   = 65536;
   localparam int STACK_BYTES = 65536;
   localparam int LABEL_COUNT = 256;

   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int STK_AW = $clog2(STACK_BYTES);
   localparam int LBL_AW = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;

   localparam logic [16:0] MEM_SPAN = 17'(MEM_BYTES);
   localparam logic [16:0] STK_SPAN = 17'(STACK_BYTES);
   localparam logic [8:0]  LBL_SPAN = 9'(LABEL_COUNT);

   // empty stack / no frame marker
   localparam logic [15:0] EMPTY_PTR = 16'hFFFF;

   // word packing
   localparam int REQ_W = 40;
   localparam int RSP_W = 72;

   typedef enum logic [3:0] {
      KIND_FETCH8    = 4'd0,
      KIND_FETCH16   = 4'd1,
      KIND_READ      = 4'd2,
      KIND_WRITE     = 4'd3,
      KIND_PUSH      = 4'd4,
      KIND_POP       = 4'd5,
      KIND_ENTER     = 4'd6,
      KIND_EXIT      = 4'd7,
      KIND_INIT      = 4'd8,
      KIND_ADD_LABEL = 4'd9,
      KIND_GET_LABEL = 4'd10,
      KIND_LOAD_PC   = 4'd11
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_EMPTY   = 2'd1,
      ERR_NOFRAME = 2'd2,
      ERR_NOLABEL = 2'd3
   } error_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_STEP1 = 2'd1,
      ST_STEP2 = 2'd2
   } state_type;

   // 16-bit pointer modulo a span of at least 256: eight compare and subtract steps
   function automatic logic [15:0] wrap_index(input logic [15:0] ptr, input logic [16:0] span);
      logic [24:0] rem;
      logic [24:0] part;
      int          i;
      rem = {9'd0, ptr};
      for (i = 7; i >= 0; i--) begin
         part = {8'd0, span} << i;
         if (rem >= part) begin
            rem = rem - part;
         end
      end
      return rem[15:0];
   endfunction

   function automatic logic [MEM_AW-1:0] mem_index(input logic [15:0] ptr);
      logic [15:0] w;
      w = wrap_index(ptr, MEM_SPAN);
      return w[MEM_AW-1:0];
   endfunction

   function automatic logic [STK_AW-1:0] stk_index(input logic [15:0] ptr);
      logic [15:0] w;
      w = wrap_index(ptr, STK_SPAN);
      return w[STK_AW-1:0];
   endfunction

   function automatic logic label_ok(input logic [7:0] lbl);
      return {1'b0, lbl} < LBL_SPAN;
   endfunction

   function automatic logic [LBL_AW-1:0] label_index(input logic [7:0] lbl);
      return lbl[LBL_AW-1:0];
   endfunction

endpackage

// ===== rtl/core/vfsf_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; read data holds while rd_en is low
module vfsf_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/vm_fetch_stack_frame_unit.sv =====
// top level of the vm fetch, stack and frame unit
// depends on vfsf_pkg and vfsf_ram
//
// Memory, stack and frame unit of a 16-bit virtual machine: one request word carries an
// operation kind in req_tuser and its operands in req_tdata, and each request gives exactly
// one response word with the data, an error code and the pc, sp and fp after the operation.
// Program memory, stack store and label targets sit in byte- or word-wide rams with one read
// and one write port and a registered read; the label valid bits are flip-flops cleared by
// reset, so no clearing pass is needed after reset. One request is in work at a time. Byte
// fetch, read, write, push, enter, init stack, label add and lookup, pc load, an empty pop
// and an exit with no frame are finished in ST_STEP1; word fetch and a pop or exit that
// finds a word on the stack go on to ST_STEP2, because their two bytes come through the
// single read port one after the other. The next request is taken in ST_IDLE, which is
// entered as the response is registered; a response still waiting in the output register
// delays only the finish of the following request. Pointers wrap at 16 bits and push has no
// overflow check.
module vm_fetch_stack_frame_unit
   import vfsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // address [15:0], data_in [31:16], label_number [39:32]
   input  logic [REQ_W-1:0] req_tdata,
   // kind [3:0]
   input  logic [3:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // data_out [15:0], error [17:16], pc_now [33:18], sp_now [49:34], fp_now [65:50], zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   // control state
   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   // architectural registers
   logic [15:0] pc_ff, pc_in;
   logic [15:0] sp_ff, sp_in;
   logic [15:0] fp_ff, fp_in;
   logic [LABEL_COUNT-1:0] valid_ff;

   // request fields held for the item in work
   kind_type    kind_ff;
   logic [15:0] din_ff;
   logic [7:0]  label_ff;
   logic [7:0]  hi_ff, hi_in;
   logic [RSP_W-1:0] rsp_data_ff;

   // request word unpacking
   kind_type    req_kind;
   logic [15:0] req_addr;
   logic [15:0] req_din;
   logic [7:0]  req_label;
   logic        req_accept;

   // ram ports
   logic              pm_we, pm_re;
   logic [MEM_AW-1:0] pm_waddr, pm_raddr;
   logic [7:0]        pm_wdata, pm_rdata;
   logic              stk_we, stk_re;
   logic [STK_AW-1:0] stk_waddr, stk_raddr;
   logic [7:0]        stk_wdata, stk_rdata;
   logic              lbl_we, lbl_re;
   logic [LBL_AW-1:0] lbl_waddr, lbl_raddr;
   logic [15:0]       lbl_wdata, lbl_rdata;

   // step control and results
   logic        out_free;
   logic        two_reads;
   logic        finish;
   logic        hi_load;
   logic        valid_set;
   logic [15:0] res_data;
   error_type   res_err;
   logic [15:0] res_pc, res_sp, res_fp;

   assign req_kind   = kind_type'(req_tuser);
   assign req_addr   = req_tdata[15:0];
   assign req_din    = req_tdata[31:16];
   assign req_label  = req_tdata[39:32];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // kinds that need a second byte read
   always_comb begin
      two_reads = 1'b0;
      case (kind_ff)
         KIND_FETCH16: two_reads = 1'b1;
         KIND_POP:     two_reads = (sp_ff != EMPTY_PTR);
         KIND_EXIT:    two_reads = (fp_ff != EMPTY_PTR);
         default:      two_reads = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_STEP1;
            end
         end
         ST_STEP1: begin
            if (two_reads) begin
               state_in = ST_STEP2;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_STEP2: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory accesses per state
   always_comb begin
      pm_we     = 1'b0;
      pm_waddr  = '0;
      pm_wdata  = '0;
      pm_re     = 1'b0;
      pm_raddr  = '0;
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      stk_re    = 1'b0;
      stk_raddr = '0;
      lbl_we    = 1'b0;
      lbl_waddr = '0;
      lbl_wdata = '0;
      lbl_re    = 1'b0;
      lbl_raddr = '0;
      valid_set = 1'b0;
      hi_load   = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  KIND_FETCH8, KIND_FETCH16: begin
                     pm_re    = 1'b1;
                     pm_raddr = mem_index(pc_ff);
                  end
                  KIND_READ: begin
                     pm_re    = 1'b1;
                     pm_raddr = mem_index(req_addr);
                  end
                  KIND_WRITE: begin
                     pm_we    = 1'b1;
                     pm_waddr = mem_index(req_addr);
                     pm_wdata = req_din[7:0];
                  end
                  KIND_PUSH: begin
                     stk_we    = 1'b1;
                     stk_waddr = stk_index(sp_ff + 16'd1);
                     stk_wdata = req_din[15:8];
                  end
                  KIND_ENTER: begin
                     stk_we    = 1'b1;
                     stk_waddr = stk_index(sp_ff + 16'd1);
                     stk_wdata = fp_ff[15:8];
                  end
                  KIND_POP: begin
                     stk_re    = (sp_ff != EMPTY_PTR);
                     stk_raddr = stk_index(sp_ff - 16'd1);
                  end
                  KIND_EXIT: begin
                     stk_re    = (fp_ff != EMPTY_PTR);
                     stk_raddr = stk_index(fp_ff - 16'd1);
                  end
                  KIND_ADD_LABEL: begin
                     lbl_we    = label_ok(req_label);
                     lbl_waddr = label_index(req_label);
                     lbl_wdata = req_din;
                     valid_set = label_ok(req_label);
                  end
                  KIND_GET_LABEL: begin
                     lbl_re    = 1'b1;
                     lbl_raddr = label_index(req_label);
                  end
                  default: ;
               endcase
            end
         end
         ST_STEP1: begin
            finish = !two_reads && out_free;
            case (kind_ff)
               KIND_FETCH16: begin
                  hi_load  = 1'b1;
                  pm_re    = 1'b1;
                  pm_raddr = mem_index(pc_ff + 16'd1);
               end
               KIND_POP: begin
                  hi_load   = two_reads;
                  stk_re    = two_reads;
                  stk_raddr = stk_index(sp_ff);
               end
               KIND_EXIT: begin
                  hi_load   = two_reads;
                  stk_re    = two_reads;
                  stk_raddr = stk_index(fp_ff);
               end
               KIND_PUSH: begin
                  stk_we    = 1'b1;
                  stk_waddr = stk_index(sp_ff + 16'd2);
                  stk_wdata = din_ff[7:0];
               end
               KIND_ENTER: begin
                  stk_we    = 1'b1;
                  stk_waddr = stk_index(sp_ff + 16'd2);
                  stk_wdata = fp_ff[7:0];
               end
               default: ;
            endcase
         end
         ST_STEP2: begin
            finish = out_free;
         end
         default: ;
      endcase
   end

   // high byte of a two-byte read
   always_comb begin
      hi_in = hi_ff;
      if (hi_load) begin
         hi_in = (kind_ff == KIND_FETCH16) ? pm_rdata : stk_rdata;
      end
   end

   // result and register updates of the finishing item
   always_comb begin
      res_data = '0;
      res_err  = ERR_OK;
      res_pc   = pc_ff;
      res_sp   = sp_ff;
      res_fp   = fp_ff;
      case (kind_ff)
         KIND_FETCH8: begin
            res_data = {8'd0, pm_rdata};
            res_pc   = pc_ff + 16'd1;
         end
         KIND_FETCH16: begin
            res_data = {hi_ff, pm_rdata};
            res_pc   = pc_ff + 16'd2;
         end
         KIND_READ: begin
            res_data = {8'd0, pm_rdata};
         end
         KIND_PUSH: begin
            res_sp = sp_ff + 16'd2;
         end
         KIND_POP: begin
            if (sp_ff == EMPTY_PTR) begin
               res_err = ERR_EMPTY;
            end else begin
               res_data = {hi_ff, stk_rdata};
               res_sp   = sp_ff - 16'd2;
            end
         end
         KIND_ENTER: begin
            res_sp = sp_ff + 16'd2;
            res_fp = sp_ff + 16'd2;
         end
         KIND_EXIT: begin
            if (fp_ff == EMPTY_PTR) begin
               res_err = ERR_NOFRAME;
            end else begin
               res_fp = {hi_ff, stk_rdata};
               res_sp = fp_ff - 16'd2;
            end
         end
         KIND_INIT: begin
            res_sp = EMPTY_PTR;
            res_fp = EMPTY_PTR;
         end
         KIND_GET_LABEL: begin
            if (label_ok(label_ff) && valid_ff[label_index(label_ff)]) begin
               res_data = lbl_rdata;
            end else begin
               res_err = ERR_NOLABEL;
            end
         end
         KIND_LOAD_PC: begin
            res_pc = din_ff;
         end
         default: ;
      endcase
   end

   assign pc_in = finish ? res_pc : pc_ff;
   assign sp_in = finish ? res_sp : sp_ff;
   assign fp_in = finish ? res_fp : fp_ff;

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         sp_ff        <= EMPTY_PTR;
         fp_ff        <= EMPTY_PTR;
         valid_ff     <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         sp_ff    <= sp_in;
         fp_ff    <= fp_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (valid_set) begin
            valid_ff[label_index(req_label)] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_kind;
         din_ff   <= req_din;
         label_ff <= req_label;
      end
      hi_ff <= hi_in;
      if (finish) begin
         rsp_data_ff <= {6'd0, res_fp, res_sp, res_pc, res_err, res_data};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // program memory
   vfsf_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_prog_mem (
      .clock   (clock),
      .wr_en   (pm_we),
      .wr_addr (pm_waddr),
      .wr_data (pm_wdata),
      .rd_en   (pm_re),
      .rd_addr (pm_raddr),
      .rd_data (pm_rdata)
   );

   // stack store
   vfsf_ram #(
      .WIDTH (8),
      .DEPTH (STACK_BYTES)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // label targets
   vfsf_ram #(
      .WIDTH (16),
      .DEPTH (LABEL_COUNT)
   ) u_label_mem (
      .clock   (clock),
      .wr_en   (lbl_we),
      .wr_addr (lbl_waddr),
      .wr_data (lbl_wdata),
      .rd_en   (lbl_re),
      .rd_addr (lbl_raddr),
      .rd_data (lbl_rdata)
   );

endmodule

// ===== rtl/core/vfsf_checker.sv =====
// port-level checker of the vm fetch, stack and frame unit, bound to the top level
// depends on vfsf_pkg and vm_fetch_stack_frame_unit_macros.svh
`include "vm_fetch_stack_frame_unit_macros.svh"

module vfsf_checker
   import vfsf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   // address [15:0], data_in [31:16], label_number [39:32]
   input logic [REQ_W-1:0] req_tdata,
   // kind [3:0]
   input logic [3:0]       req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   // data_out [15:0], error [17:16], pc_now [33:18], sp_now [49:34], fp_now [65:50], zero pad
   input logic [RSP_W-1:0] rsp_tdata
);

   // a stalled response word holds
   `VFSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one request at a time: busy right after an accept
   `VFSF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // an empty pop leaves the stack pointer at the empty mark
   `VFSF_ASSERT_SAME(a_empty_pop_sp, clock, reset, rsp_tvalid && rsp_tdata[17:16] == ERR_EMPTY, rsp_tdata[49:34] == EMPTY_PTR)

   // a failed exit leaves the frame pointer at the no-frame mark
   `VFSF_ASSERT_SAME(a_noframe_fp, clock, reset, rsp_tvalid && rsp_tdata[17:16] == ERR_NOFRAME, rsp_tdata[65:50] == EMPTY_PTR)

endmodule

bind vm_fetch_stack_frame_unit vfsf_checker u_vfsf_checker (.*);

// ===== verif/vfsf_result_checker.sv =====
// response checker for the vm fetch, stack and frame unit
// depends on vfsf_pkg; watches both stream channels and counts mismatches
module vfsf_result_checker
   import vfsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // address [15:0], data_in [31:16], label_number [39:32]
   input  logic [REQ_W-1:0] req_tdata,
   // kind [3:0]
   input  logic [3:0]       req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // data_out [15:0], error [17:16], pc_now [33:18], sp_now [49:34], fp_now [65:50], zero pad
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               error_count,
   output int               pending
);

   typedef struct packed {
      logic [15:0] data;
      error_type   err;
      logic [15:0] pc;
      logic [15:0] sp;
      logic [15:0] fp;
   } vm_result_type;

   // predicted machine state
   logic [7:0]  prog_bytes   [MEM_BYTES];
   logic [7:0]  stack_bytes  [STACK_BYTES];
   logic [15:0] label_target [LABEL_COUNT];
   bit          label_set    [LABEL_COUNT];
   logic [15:0] pc_q;
   logic [15:0] sp_q;
   logic [15:0] fp_q;

   // one expected response word per accepted request word, oldest first
   vm_result_type results_due [$];

   function automatic int prog_slot(input logic [15:0] ptr);
      return int'(ptr) % MEM_BYTES;
   endfunction

   function automatic int stack_slot(input logic [15:0] ptr);
      return int'(ptr) % STACK_BYTES;
   endfunction

   // high byte just below the top, low byte at the top
   function automatic logic [15:0] stack_word(input logic [15:0] top);
      return {stack_bytes[stack_slot(top - 16'd1)], stack_bytes[stack_slot(top)]};
   endfunction

   function automatic void push_word(input logic [15:0] value);
      stack_bytes[stack_slot(sp_q + 16'd1)] = value[15:8];
      stack_bytes[stack_slot(sp_q + 16'd2)] = value[7:0];
      sp_q = sp_q + 16'd2;
   endfunction

   // carry out one operation on the predicted state and return its response
   function automatic vm_result_type apply_vm_op(input logic [3:0] op, input logic [15:0] addr,
                                                 input logic [15:0] data, input logic [7:0] lbl);
      vm_result_type res;
      logic [15:0]   saved_fp;
      res = '0;
      case (op)
         KIND_FETCH8: begin
            res.data = {8'h00, prog_bytes[prog_slot(pc_q)]};
            pc_q = pc_q + 16'd1;
         end
         KIND_FETCH16: begin
            res.data = {prog_bytes[prog_slot(pc_q)], prog_bytes[prog_slot(pc_q + 16'd1)]};
            pc_q = pc_q + 16'd2;
         end
         KIND_READ: begin
            res.data = {8'h00, prog_bytes[prog_slot(addr)]};
         end
         KIND_WRITE: begin
            prog_bytes[prog_slot(addr)] = data[7:0];
         end
         KIND_PUSH: begin
            push_word(data);
         end
         KIND_POP: begin
            if (sp_q == EMPTY_PTR) begin
               res.err = ERR_EMPTY;
            end else begin
               res.data = stack_word(sp_q);
               sp_q = sp_q - 16'd2;
            end
         end
         KIND_ENTER: begin
            push_word(fp_q);
            fp_q = sp_q;
         end
         KIND_EXIT: begin
            if (fp_q == EMPTY_PTR) begin
               res.err = ERR_NOFRAME;
            end else begin
               saved_fp = stack_word(fp_q);
               sp_q = fp_q - 16'd2;
               fp_q = saved_fp;
            end
         end
         KIND_INIT: begin
            sp_q = EMPTY_PTR;
            fp_q = EMPTY_PTR;
         end
         KIND_ADD_LABEL: begin
            if (int'(lbl) < LABEL_COUNT) begin
               label_target[lbl] = data;
               label_set[lbl] = 1'b1;
            end
         end
         KIND_GET_LABEL: begin
            if (int'(lbl) < LABEL_COUNT && label_set[lbl]) begin
               res.data = label_target[lbl];
            end else begin
               res.err = ERR_NOLABEL;
            end
         end
         KIND_LOAD_PC: begin
            pc_q = data;
         end
         default: begin
         end
      endcase
      res.pc = pc_q;
      res.sp = sp_q;
      res.fp = fp_q;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s mismatch: expected %h, got %h", name, want, got);
      end
   endfunction

   // responses are matched before the request of the same edge is predicted
   always @(posedge clock) begin : watch
      vm_result_type want;
      vm_result_type got;
      if (reset) begin
         pc_q = '0;
         sp_q = EMPTY_PTR;
         fp_q = EMPTY_PTR;
         foreach (label_set[i]) label_set[i] = 1'b0;
         results_due.delete();
         error_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.data = rsp_tdata[15:0];
            got.err  = error_type'(rsp_tdata[17:16]);
            got.pc   = rsp_tdata[33:18];
            got.sp   = rsp_tdata[49:34];
            got.fp   = rsp_tdata[65:50];
            if (results_due.size() == 0) begin
               error_count++;
               $error("response word with no request outstanding");
            end else begin
               want = results_due.pop_front();
               check_field("data_out", want.data, got.data);
               check_field("error", 16'(want.err), 16'(got.err));
               check_field("pc_now", want.pc, got.pc);
               check_field("sp_now", want.sp, got.sp);
               check_field("fp_now", want.fp, got.fp);
            end
         end
         if (req_tvalid && req_tready) begin
            results_due.insert(results_due.size(),
                               apply_vm_op(req_tuser, req_tdata[15:0], req_tdata[31:16],
                                           req_tdata[39:32]));
         end
      end
      pending = results_due.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the vm fetch, stack and frame unit: clock, reset, stimulus and verdict
// depends on vfsf_pkg, vm_fetch_stack_frame_unit and vfsf_result_checker
module tb_top;
   import vfsf_pkg::*;

   localparam logic [3:0] KIND_SPARE_FIRST = 4'd12;
   localparam logic [3:0] KIND_SPARE_LAST  = 4'd15;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int CALM_FROM    = 900;
   localparam int CALM_TO      = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 1000000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [3:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               results_pending;

   // pointers and written bytes as of the last word sent, so reads only hit written data
   logic [15:0] next_pc;
   logic [15:0] next_sp;
   logic [15:0] next_fp;
   bit          prog_written  [MEM_BYTES];
   bit          stack_written [STACK_BYTES];
   logic [7:0]  stack_shadow  [STACK_BYTES];
   logic [15:0] prog_addrs [$];

   int words_sent;
   bit hold_active;
   bit hold_done;

   vm_fetch_stack_frame_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   vfsf_result_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (fail_count),
      .pending     (results_pending)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit in_calm();
      return words_sent >= CALM_FROM && words_sent < CALM_TO;
   endfunction

   // idle stretch length: mostly short, a few long
   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int send_gap();
      if (hold_active || in_calm()) return 0;
      if ($urandom_range(0, 1) == 0) return 0;
      return idle_span();
   endfunction

   function automatic bit stack_ready(input logic [15:0] top);
      return stack_written[top - 16'd1] && stack_written[top];
   endfunction

   function automatic void shadow_push(input logic [15:0] value);
      stack_shadow[next_sp + 16'd1]  = value[15:8];
      stack_shadow[next_sp + 16'd2]  = value[7:0];
      stack_written[next_sp + 16'd1] = 1'b1;
      stack_written[next_sp + 16'd2] = 1'b1;
      next_sp = next_sp + 16'd2;
   endfunction

   // track what a sent word does to pointers and stored bytes
   function automatic void note_sent(input logic [3:0] op, input logic [15:0] addr,
                                     input logic [15:0] data);
      logic [15:0] saved_fp;
      case (op)
         KIND_FETCH8:  next_pc = next_pc + 16'd1;
         KIND_FETCH16: next_pc = next_pc + 16'd2;
         KIND_WRITE: begin
            if (!prog_written[addr]) prog_addrs.insert(prog_addrs.size(), addr);
            prog_written[addr] = 1'b1;
         end
         KIND_PUSH: shadow_push(data);
         KIND_POP: begin
            if (next_sp != EMPTY_PTR) next_sp = next_sp - 16'd2;
         end
         KIND_ENTER: begin
            shadow_push(next_fp);
            next_fp = next_sp;
         end
         KIND_EXIT: begin
            if (next_fp != EMPTY_PTR) begin
               saved_fp = {stack_shadow[next_fp - 16'd1], stack_shadow[next_fp]};
               next_sp = next_fp - 16'd2;
               next_fp = saved_fp;
            end
         end
         KIND_INIT: begin
            next_sp = EMPTY_PTR;
            next_fp = EMPTY_PTR;
         end
         KIND_LOAD_PC: next_pc = data;
         default: begin
         end
      endcase
   endfunction

   // offer one request word and hold it until accepted
   task automatic send_op(input logic [3:0] op, input logic [15:0] addr,
                          input logic [15:0] data, input logic [7:0] lbl);
      int gap;
      gap = send_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {lbl, data, addr};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      note_sent(op, addr, data);
      words_sent++;
   endtask

   // random operation, turned into a write or init where it would read unwritten data
   task automatic random_op(output logic [3:0] op, output logic [15:0] addr,
                            output logic [15:0] data, output logic [7:0] lbl);
      int roll;
      addr = 16'($urandom_range(0, 16'hFFFF));
      data = 16'($urandom_range(0, 16'hFFFF));
      lbl  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 12)      op = KIND_FETCH8;
      else if (roll < 22) op = KIND_FETCH16;
      else if (roll < 32) op = KIND_READ;
      else if (roll < 47) op = KIND_WRITE;
      else if (roll < 61) op = KIND_PUSH;
      else if (roll < 73) op = KIND_POP;
      else if (roll < 78) op = KIND_ENTER;
      else if (roll < 83) op = KIND_EXIT;
      else if (roll < 85) op = KIND_INIT;
      else if (roll < 90) op = KIND_ADD_LABEL;
      else if (roll < 96) op = KIND_GET_LABEL;
      else if (roll < 98) op = KIND_LOAD_PC;
      else                op = 4'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));

      // keep program writes mostly near the ends of memory
      roll = $urandom_range(0, 99);
      if (op == KIND_WRITE && roll < 60) addr = 16'($urandom_range(0, 255));
      else if (op == KIND_WRITE && roll < 75) addr = 16'($urandom_range(16'hFF00, 16'hFFFF));
      // jumps mostly land on written code
      if (op == KIND_LOAD_PC && roll < 60 && prog_addrs.size() > 0) begin
         data = prog_addrs[$urandom_range(0, prog_addrs.size() - 1)];
      end else if (op == KIND_LOAD_PC && roll < 80) begin
         data = '0;
      end

      case (op)
         KIND_FETCH8: begin
            if (!prog_written[next_pc]) begin
               op = KIND_WRITE;
               addr = next_pc;
            end
         end
         KIND_FETCH16: begin
            if (!prog_written[next_pc]) begin
               op = KIND_WRITE;
               addr = next_pc;
            end else if (!prog_written[next_pc + 16'd1]) begin
               op = KIND_WRITE;
               addr = next_pc + 16'd1;
            end
         end
         KIND_READ: begin
            if (prog_addrs.size() == 0) op = KIND_WRITE;
            else addr = prog_addrs[$urandom_range(0, prog_addrs.size() - 1)];
         end
         KIND_POP: begin
            if (next_sp != EMPTY_PTR && !stack_ready(next_sp)) op = KIND_INIT;
         end
         KIND_EXIT: begin
            if (next_fp != EMPTY_PTR && !stack_ready(next_fp)) op = KIND_INIT;
         end
         default: begin
         end
      endcase
   endtask

   // response side: random stalls, one long hold-off, a calm stretch
   initial begin : response_side
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && words_sent >= HOLD_AT) begin
            hold_active = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
            hold_done = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else if (in_calm() || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            stall_left = idle_span() - 1;
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      logic [3:0]  op;
      logic [15:0] addr;
      logic [15:0] data;
      logic [7:0]  lbl;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      next_pc = '0;
      next_sp = EMPTY_PTR;
      next_fp = EMPTY_PTR;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty pop, exit with no frame, missing labels at both ends of the table
      send_op(KIND_POP, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_EXIT, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_op(KIND_GET_LABEL, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_GET_LABEL, 16'h0000, 16'h0000, 8'hFF);
      // program bytes at both ends; only the low byte of data_in is stored
      send_op(KIND_WRITE, 16'h0000, 16'hFF5A, 8'h00);
      send_op(KIND_WRITE, 16'hFFFF, 16'h00C3, 8'h00);
      send_op(KIND_WRITE, 16'h0001, 16'hFFFF, 8'hFF);
      send_op(KIND_READ, 16'hFFFF, 16'h0000, 8'h00);
      send_op(KIND_READ, 16'h0001, 16'hFFFF, 8'hFF);
      // word fetch across the top of memory wraps pc, then a byte fetch
      send_op(KIND_LOAD_PC, 16'h0000, 16'hFFFF, 8'h00);
      send_op(KIND_FETCH16, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_FETCH8, 16'h0000, 16'h0000, 8'h00);
      // push from the empty stack wraps sp; one frame around a pushed word
      send_op(KIND_PUSH, 16'h0000, 16'hFFFF, 8'h00);
      send_op(KIND_PUSH, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_ENTER, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_PUSH, 16'h0000, 16'h8001, 8'h00);
      send_op(KIND_EXIT, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_POP, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_POP, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_POP, 16'h0000, 16'h0000, 8'h00);
      // labels at both ends of the table
      send_op(KIND_ADD_LABEL, 16'h0000, 16'hFFFF, 8'h00);
      send_op(KIND_ADD_LABEL, 16'h0000, 16'h0000, 8'hFF);
      send_op(KIND_GET_LABEL, 16'hFFFF, 16'hFFFF, 8'h00);
      send_op(KIND_GET_LABEL, 16'h0000, 16'h0000, 8'hFF);
      // unused kinds change nothing
      send_op(KIND_SPARE_FIRST, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_op(KIND_SPARE_LAST, 16'hFFFF, 16'hFFFF, 8'hFF);
      // init drops an open frame
      send_op(KIND_ENTER, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_INIT, 16'h0000, 16'h0000, 8'h00);
      send_op(KIND_EXIT, 16'h0000, 16'h0000, 8'h00);

      repeat (RANDOM_ITEMS) begin
         random_op(op, addr, data, lbl);
         send_op(op, addr, data, lbl);
      end
      req_tvalid <= 1'b0;

      // drain the outstanding responses, then let the bench idle before the verdict
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== vm_fetch_stack_frame_unit.f =====
+incdir+rtl/core
rtl/core/vfsf_pkg.sv
rtl/core/vfsf_ram.sv
rtl/core/vm_fetch_stack_frame_unit.sv
rtl/core/vfsf_checker.sv
verif/vfsf_result_checker.sv
verif/tb_top.sv
